/* sv/mlse_pkg.sv */
// types and constants shared by the mpls label stack editor modules
// no dependencies
`default_nettype none

package mlse_pkg;

   localparam logic [2:0] MODE_WRITE    = 3'd0;
   localparam logic [2:0] MODE_REMOVE   = 3'd1;
   localparam logic [2:0] MODE_SET_BOS  = 3'd2;
   localparam logic [2:0] MODE_CLR_BOS  = 3'd3;
   localparam logic [2:0] MODE_LOAD_ETH = 3'd4;

   localparam logic [23:0] LABEL_MAX   = 24'd1048575;
   localparam logic [7:0]  EXP_MAX     = 8'd7;
   localparam logic [15:0] ETH_MPLS_UC = 16'h8847;
   localparam logic [15:0] ETH_MPLS_MC = 16'h8848;
   localparam logic        STATUS_OK   = 1'b0;
   localparam logic        STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [4:0]  position;
      logic [4:0]  stack_total;
      logic [23:0] label;
      logic [7:0]  exp_bits;
      logic [7:0]  ttl;
      logic [15:0] ethertype_in;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [4:0]  tag_count;
      logic        mpls_active;
      logic [15:0] ethertype_out;
      logic [31:0] tag_word;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic commit;
   } dp_cmd_type;

endpackage

`default_nettype wire

/* sv/mlse_dp.sv */
// datapath: request register, tag store, stack state and result register
// depends on mlse_pkg
`default_nettype none

module mlse_dp #(
   parameter int MAX_TAGS = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  mlse_pkg::dp_cmd_type    cmd,
   input  mlse_pkg::req_type       req_data,
   output mlse_pkg::rsp_type       rsp_data
);
   import mlse_pkg::*;

   localparam int         IDX_W      = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam logic [6:0] MAX_TAGS_W = 7'(MAX_TAGS);

   req_type     req_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] store_ff [MAX_TAGS];
   logic [31:0] store_in [MAX_TAGS];
   logic [31:0] nbr      [MAX_TAGS];
   logic [4:0]  count_ff, count_in;
   logic        active_ff, active_in;
   logic [15:0] cur_eth_ff, cur_eth_in;
   logic [15:0] saved_eth_ff, saved_eth_in;

   logic [6:0]       pos7, pm1, tot7, cnt7;
   logic             pos_in_range, pm1_in_range, last_tag, ok;
   logic             do_write, do_shift, do_bos;
   logic [IDX_W-1:0] wr_idx, pm1_idx;
   logic [31:0]      new_word;

   genvar g;
   generate
      for (g = 0; g < MAX_TAGS; g++) begin : g_nbr
         if (g < MAX_TAGS - 1) begin : g_mid
            assign nbr[g] = store_ff[g + 1];
         end else begin : g_end
            assign nbr[g] = '0;
         end
      end
   endgenerate

   always_comb begin
      pos7         = {2'b00, req_ff.position};
      tot7         = {2'b00, req_ff.stack_total};
      cnt7         = {2'b00, count_ff};
      pm1          = pos7 - 7'd1;
      pos_in_range = pos7 < MAX_TAGS_W;
      pm1_in_range = (pos7 != 7'd0) && (pm1 < MAX_TAGS_W);
      wr_idx       = pos7[IDX_W-1:0];
      pm1_idx      = pm1[IDX_W-1:0];
      last_tag     = (tot7 != 7'd0) && (pos7 == tot7 - 7'd1);
      new_word     = {req_ff.label[19:0], req_ff.exp_bits[2:0], last_tag, req_ff.ttl};

      ok           = 1'b0;
      do_write     = 1'b0;
      do_shift     = 1'b0;
      do_bos       = 1'b0;
      count_in     = count_ff;
      active_in    = active_ff;
      cur_eth_in   = cur_eth_ff;
      saved_eth_in = saved_eth_ff;

      case (req_ff.mode)
         MODE_WRITE: begin
            ok = pos_in_range && !((tot7 != 7'd0) && (pos7 >= tot7))
                 && (req_ff.label <= LABEL_MAX) && (req_ff.exp_bits <= EXP_MAX);
            do_write = ok;
            if (ok && last_tag) begin
               count_in  = req_ff.stack_total;
               active_in = 1'b1;
               if (cur_eth_ff != ETH_MPLS_UC && cur_eth_ff != ETH_MPLS_MC) begin
                  saved_eth_in = cur_eth_ff;
               end
               cur_eth_in = ETH_MPLS_UC;
            end
         end
         MODE_REMOVE: begin
            if (pos7 == 7'd0) begin
               ok = active_ff;
               if (ok) begin
                  count_in   = '0;
                  active_in  = 1'b0;
                  cur_eth_in = saved_eth_ff;
               end
            end else if (pos7 <= cnt7) begin
               ok = 1'b1;
               if (count_ff == 5'd1) begin
                  count_in   = '0;
                  active_in  = 1'b0;
                  cur_eth_in = saved_eth_ff;
               end else begin
                  do_shift = 1'b1;
                  count_in = count_ff - 5'd1;
               end
            end
         end
         MODE_SET_BOS, MODE_CLR_BOS: begin
            ok     = (pos7 != 7'd0) && (pos7 <= cnt7) && (pos7 <= MAX_TAGS_W);
            do_bos = ok;
         end
         MODE_LOAD_ETH: begin
            ok         = 1'b1;
            cur_eth_in = req_ff.ethertype_in;
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      for (int i = 0; i < MAX_TAGS; i++) begin
         store_in[i] = store_ff[i];
         if (do_write && wr_idx == IDX_W'(i)) begin
            store_in[i] = new_word;
         end
         if (do_shift && (7'(i) >= pm1) && (7'(i) + 7'd1 < cnt7)
             && (7'(i) < MAX_TAGS_W - 7'd1)) begin
            store_in[i] = nbr[i];
         end
         if (do_bos && pm1_idx == IDX_W'(i)) begin
            store_in[i][8] = (req_ff.mode == MODE_SET_BOS);
         end
      end

      rsp_in.status        = ok ? STATUS_OK : STATUS_FAIL;
      rsp_in.tag_count     = count_in;
      rsp_in.mpls_active   = active_in;
      rsp_in.ethertype_out = cur_eth_in;
      rsp_in.tag_word      = '0;
      if (req_ff.mode == MODE_WRITE) begin
         if (pos_in_range) begin
            rsp_in.tag_word = store_in[wr_idx];
         end
      end else if (req_ff.mode <= MODE_CLR_BOS) begin
         if (pm1_in_range) begin
            rsp_in.tag_word = store_in[pm1_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         count_ff     <= '0;
         active_ff    <= 1'b0;
         cur_eth_ff   <= '0;
         saved_eth_ff <= '0;
         for (int i = 0; i < MAX_TAGS; i++) begin
            store_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         count_ff     <= count_in;
         active_ff    <= active_in;
         cur_eth_ff   <= cur_eth_in;
         saved_eth_ff <= saved_eth_in;
         for (int i = 0; i < MAX_TAGS; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* sv/mlse_ctrl.sv */
// controller: beat handshakes and sequencing of capture and execute
// depends on mlse_pkg
`default_nettype none

module mlse_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output mlse_pkg::dp_cmd_type    cmd
);
   import mlse_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      out_free     = !rsp_valid_ff || !rsp_stall;
      cmd.load_req = req_valid && !req_stall;
      cmd.commit   = (state_ff == ST_EXEC) && out_free;
      state_in     = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load_req) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* sv/mpls_label_stack_editor_top.sv */
// top level of the mpls label stack editor: controller plus datapath
// depends on mlse_pkg, mlse_ctrl and mlse_dp
`default_nettype none

// Edits a stack of up to MAX_TAGS 32-bit MPLS tags (label, EXP, BoS, TTL in
// network order) together with a tag count, an active flag and the current
// and saved ethertype. Each request beat carries one command and returns one
// response beat. An item is captured into the request register, then the
// execute state runs the edit (including the one-slot shift-down of a remove)
// on the tag register file and loads the response register. A response that
// is still stalled holds the next item in execute until the register frees.

module mpls_label_stack_editor_top #(
   parameter int MAX_TAGS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  mlse_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output mlse_pkg::rsp_type    rsp_data
);
   import mlse_pkg::*;

   dp_cmd_type cmd;

   mlse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mlse_dp #(
      .MAX_TAGS (MAX_TAGS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   a_commit_gives_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("executed item did not produce a response beat");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> (req_stall && !cmd.load_req))
      else $error("request accepted while previous item in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({2'b00, rsp_data.tag_count} <= 7'(MAX_TAGS)))
      else $error("tag count exceeds stack depth");

   a_active_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.mpls_active == (rsp_data.tag_count != 5'd0)))
      else $error("active flag disagrees with tag count");

endmodule

`default_nettype wire
